// ===== design/sbps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Strided byte pattern search - shared package
// Types, register indexes and fixed field widths used across the design.
// ----------------------------------------------------------------------------
package sbps_pkg;

    // Fixed field widths.
    localparam int BYTE_W      = 8;
    localparam int MSTART_W    = 24;
    localparam int PAT_BYTES   = 32;
    localparam int PAT_WORDS   = 4;
    localparam int PWORD_W     = 64;
    localparam int LEN_W       = 6;
    localparam int STRIDE_W    = 5;
    localparam int OFFSET_W    = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_WORD0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_WORD1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_WORD2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_WORD3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LENGTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_START_OFFS  = 3'd6;

    // One input item.
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic                match;
        logic [MSTART_W-1:0] match_start;
        logic                first_match_res;
    } t_out_item;

    // Configuration register contents.
    typedef struct packed {
        logic [PAT_WORDS-1:0][PWORD_W-1:0] pattern;
        logic [LEN_W-1:0]                  pattern_length;
        logic [STRIDE_W-1:0]               stride;
        logic [OFFSET_W-1:0]               start_offset;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic setup;
        logic check;
        logic scan;
        logic load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic eligible;
        logic pass;
        logic fail;
    } t_dp_sts;

endpackage
`default_nettype wire

// ===== design/sbps_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Strided byte pattern search - configuration registers
// Holds the pattern words, length, stride and start offset.
// ----------------------------------------------------------------------------
module sbps_cfg
    import sbps_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    // Register writes; indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern        <= '0;
            r_cfg.pattern_length <= '0;
            r_cfg.stride         <= STRIDE_W'(1);
            r_cfg.start_offset   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PAT_WORD0:  r_cfg.pattern[0]     <= i_cfg_data;
                CFG_PAT_WORD1:  r_cfg.pattern[1]     <= i_cfg_data;
                CFG_PAT_WORD2:  r_cfg.pattern[2]     <= i_cfg_data;
                CFG_PAT_WORD3:  r_cfg.pattern[3]     <= i_cfg_data;
                CFG_PAT_LENGTH: r_cfg.pattern_length <= i_cfg_data[LEN_W-1:0];
                CFG_STRIDE:     r_cfg.stride         <= i_cfg_data[STRIDE_W-1:0];
                CFG_START_OFFS: r_cfg.start_offset   <= i_cfg_data[OFFSET_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ===== design/sbps_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Strided byte pattern search - controller
// Sequences accept, span setup, eligibility check, history scan and result load.
// ----------------------------------------------------------------------------
module sbps_ctrl
    import sbps_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_dp_cmd      o_cmd,
    input  wire t_dp_sts i_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_CHECK,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   n_out_valid;

    // Commands follow the state and the handshakes.
    always_comb begin
        o_cmd.accept = r_in_ready && i_in_valid;
        o_cmd.setup  = (r_state == S_SETUP);
        o_cmd.check  = (r_state == S_CHECK);
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.load   = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.accept) n_state = S_SETUP;
            end
            S_SETUP: n_state = S_CHECK;
            S_CHECK: n_state = S_SCAN;
            S_SCAN: begin
                if (!i_sts.eligible || i_sts.fail || i_sts.pass) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (o_cmd.load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // The output item stays valid until taken, unless a new one replaces it.
    always_comb begin
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // State and registered handshake outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= (n_state == S_IDLE);
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// ===== design/sbps_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Strided byte pattern search - datapath
// History memory, stream position, span arithmetic, byte compare and result.
// ----------------------------------------------------------------------------
module sbps_datapath
    import sbps_pkg::*;
#(
    parameter int MAX_PATTERN   = 32,
    parameter int MAX_STRIDE    = 16,
    parameter int HISTORY_DEPTH = 512,
    parameter int POSITION_BITS = 24
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire t_in_item i_in_item,
    input  wire t_dp_cmd  i_cmd,
    output t_dp_sts       o_sts,
    output t_out_item     o_out_item
);

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int SW = $clog2(MAX_STRIDE + 1);
    localparam int MW = LW + SW;
    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int PW = POSITION_BITS;

    // History store.
    logic [BYTE_W-1:0] r_mem [HISTORY_DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    // Stream state.
    logic [PW-1:0] r_pos;
    logic [AW-1:0] r_wptr;
    logic          r_found;
    logic          r_last;

    // Per-item working registers.
    logic [LW-1:0] r_len;
    logic [SW-1:0] r_st;
    logic [MW-1:0] r_span_m1;
    logic          r_elig;
    logic [PW-1:0] r_start;
    logic [AW-1:0] r_addr;
    logic [LW-1:0] r_issue;
    logic          r_dv;
    logic [LW-1:0] r_dv_idx;
    logic          r_hit;
    t_out_item     r_out;

    logic [6:0]    len7;
    logic [6:0]    st7;
    logic [LW-1:0] len_c;
    logic [SW-1:0] st_c;
    logic [LW-1:0] len_m1;
    logic          elig_c;
    logic [AW:0]   start_diff;
    logic [AW-1:0] start_addr;
    logic [AW:0]   step_sum;
    logic [AW-1:0] next_addr;
    logic          rd_en;
    logic [PAT_BYTES-1:0][BYTE_W-1:0] pat_bytes;
    logic [BYTE_W-1:0] pat_byte;
    logic          byte_eq;
    logic [31:0]   start32;
    logic          first_c;

    // Clamp length and stride to their supported ranges.
    always_comb begin
        len7 = {1'b0, i_cfg.pattern_length};
        if (32'(len7) > 32'(MAX_PATTERN)) begin
            len7 = 7'(MAX_PATTERN);
        end
        st7 = {2'b00, i_cfg.stride};
        if (st7 == 7'd0) begin
            st7 = 7'd1;
        end else if (32'(st7) > 32'(MAX_STRIDE)) begin
            st7 = 7'(MAX_STRIDE);
        end
        len_c  = LW'(len7);
        st_c   = SW'(st7);
        len_m1 = (len_c == '0) ? '0 : len_c - LW'(1);
    end

    // A match must fit in the history and start at or after position zero.
    assign elig_c = (r_len != '0)
                 && (32'(r_span_m1) < 32'(HISTORY_DEPTH))
                 && (32'(r_pos) >= 32'(r_span_m1));

    // Start address of the span, wrapped into the history store.
    always_comb begin
        start_diff = {1'b0, r_wptr} - (AW+1)'(r_span_m1);
        if (start_diff[AW]) begin
            start_addr = AW'(start_diff + (AW+1)'(HISTORY_DEPTH));
        end else begin
            start_addr = AW'(start_diff);
        end
    end

    // Advance the read address by one stride, modulo the history depth.
    always_comb begin
        step_sum = {1'b0, r_addr} + (AW+1)'(r_st);
        if (32'(step_sum) >= 32'(HISTORY_DEPTH)) begin
            next_addr = AW'(step_sum - (AW+1)'(HISTORY_DEPTH));
        end else begin
            next_addr = AW'(step_sum);
        end
    end

    assign rd_en = i_cmd.scan && r_elig && (r_issue < r_len);

    // Pattern bytes beyond the stored words read as zero.
    assign pat_bytes = i_cfg.pattern;
    always_comb begin
        if (32'(r_dv_idx) < PAT_BYTES) begin
            pat_byte = pat_bytes[5'(r_dv_idx)];
        end else begin
            pat_byte = '0;
        end
    end

    assign byte_eq    = (r_rd_data == pat_byte);
    assign o_sts.eligible = r_elig;
    assign o_sts.fail = r_dv && !byte_eq;
    assign o_sts.pass = r_dv && byte_eq && (r_dv_idx == r_len - LW'(1));

    // History write on accept, registered read during the scan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mem[r_wptr] <= i_in_item.data_byte;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    // Span setup, eligibility check and scan bookkeeping.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_last <= i_in_item.last_byte;
        end
        if (i_cmd.setup) begin
            r_len     <= len_c;
            r_st      <= st_c;
            r_span_m1 <= MW'(len_m1) * MW'(st_c);
        end
        if (i_cmd.check) begin
            r_elig  <= elig_c;
            r_start <= r_pos - PW'(r_span_m1);
            r_addr  <= start_addr;
            r_issue <= '0;
            r_hit   <= 1'b0;
        end
        if (rd_en) begin
            r_addr  <= next_addr;
            r_issue <= r_issue + LW'(1);
        end
        if (i_cmd.scan && o_sts.pass) begin
            r_hit <= 1'b1;
        end
        r_dv_idx <= r_issue;
    end

    // Read data valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
        end else if (i_cmd.check) begin
            r_dv <= 1'b0;
        end else begin
            r_dv <= rd_en;
        end
    end

    // First-match decision on the finished item.
    assign start32 = 32'(r_start);
    assign first_c = r_hit && !r_found && (start32 >= 32'(i_cfg.start_offset));

    // Stream position, write pointer and found mark advance as the result loads, or restart after the last byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_wptr  <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.load) begin
            if (r_last) begin
                r_pos   <= '0;
                r_wptr  <= '0;
                r_found <= 1'b0;
            end else begin
                r_pos <= r_pos + PW'(1);
                if ((r_pos == {PW{1'b1}}) || (32'(r_wptr) == HISTORY_DEPTH - 1)) begin
                    r_wptr <= '0;
                end else begin
                    r_wptr <= r_wptr + AW'(1);
                end
                if (first_c) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out.match           <= r_hit;
            r_out.match_start     <= r_hit ? start32[MSTART_W-1:0] : '0;
            r_out.first_match_res <= first_c;
        end
    end

    assign o_out_item = r_out;

endmodule
`default_nettype wire

// ===== design/strided_byte_pattern_search_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Strided byte pattern search - top level
// Reports for each stream byte whether a strided pattern match ends there.
// ----------------------------------------------------------------------------
// Each byte yields one result item. The scan reads one history byte per
// cycle through the single read port of the history memory and stops at
// the first mismatch; it reads nothing when the pattern is disabled or too
// few bytes have been seen in the current stream. A finished result sits in
// an output register, so the next byte is accepted while it waits. Matches
// must lie wholly in the current stream; last_byte restarts the position count
// and the first-match mark after its result. The history memory needs no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module strided_byte_pattern_search_core
    import sbps_pkg::*;
#(
    parameter int MAX_PATTERN   = 32,
    parameter int MAX_STRIDE    = 16,
    parameter int HISTORY_DEPTH = 512,
    parameter int POSITION_BITS = 24
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_item,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;

    // Configuration registers.
    sbps_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Sequencer.
    sbps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // History, compare and result datapath.
    sbps_datapath #(
        .MAX_PATTERN   (MAX_PATTERN),
        .MAX_STRIDE    (MAX_STRIDE),
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .POSITION_BITS (POSITION_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_item  (i_in_item),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_item (o_out_item)
    );

endmodule
`default_nettype wire
